FILE: rtl/vobp_pkg.sv
// Shared constants, codes and handshake types for the video-out beam position unit.
`default_nettype none
package vobp_pkg;

  localparam int DIM_BITS_DEF   = 13;
  localparam int CYCLE_BITS_DEF = 48;

  // Datapath width of the shared multiply/divide unit and its step counter.
  localparam int UNIT_W = 64;
  localparam int CNT_W  = 7;
  localparam int POS_W  = 24;
  localparam int X_W    = 12;
  localparam int Y_W    = 14;
  localparam logic [X_W-1:0] X_MAX = '1;
  localparam logic [Y_W-1:0] Y_MAX = '1;

  localparam logic [2:0] MODE_READ    = 3'd0;
  localparam logic [2:0] MODE_DITHER  = 3'd1;
  localparam logic [2:0] MODE_SIZE    = 3'd2;
  localparam logic [2:0] MODE_SEAL    = 3'd3;
  localparam logic [2:0] MODE_PRES_LV = 3'd4;
  localparam logic [2:0] MODE_PRES_FR = 3'd5;
  localparam logic [2:0] MODE_ALIGN   = 3'd6;
  localparam logic [2:0] MODE_REINIT  = 3'd7;

  localparam logic [1:0] STAT_IDLE    = 2'd0;
  localparam logic [1:0] STAT_LATCHED = 2'd1;
  localparam logic [1:0] STAT_SEALED  = 2'd2;
  localparam logic [1:0] STAT_SHOWN   = 2'd3;

  localparam logic REG_CPF = 1'b0;
  localparam logic REG_VBS = 1'b1;

  typedef enum logic {OP_MUL, OP_DIV} arith_op_e;

  typedef struct packed {
    logic              start;
    arith_op_e         op;
    logic [UNIT_W-1:0] a;      // multiplier, or dividend
    logic [UNIT_W-1:0] b;      // multiplicand, or divisor
    logic [CNT_W-1:0]  nbits;  // significant bits of a
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [UNIT_W-1:0] quo;    // quotient
    logic [UNIT_W-1:0] rem;    // remainder, or product
  } arith_resp_t;

endpackage
`default_nettype wire

FILE: rtl/vobp_arith.sv
// Shared bit-serial multiply and restoring divide unit, one bit per cycle.
`default_nettype none
module vobp_arith
  import vobp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire arith_req_t  req_i,
  output arith_resp_t      resp_o
);

  logic              busy_q, done_q;
  arith_op_e         op_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [UNIT_W-1:0] acc_q, shf_q, opb_q;

  logic [UNIT_W-1:0] rn;
  logic [UNIT_W:0]   df;
  logic [CNT_W-1:0]  lsh;

  assign rn  = {acc_q[UNIT_W-2:0], shf_q[UNIT_W-1]};
  assign df  = {1'b0, rn} - {1'b0, opb_q};
  assign lsh = CNT_W'(UNIT_W) - req_i.nbits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      acc_q <= '0;
      opb_q <= req_i.b;
      // The dividend is left-aligned so its top bit enters the remainder first.
      shf_q <= (req_i.op == OP_DIV) ? (req_i.a << lsh) : req_i.a;
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        acc_q <= acc_q + (shf_q[0] ? opb_q : '0);
        shf_q <= shf_q >> 1;
        opb_q <= opb_q << 1;
      end else if (!df[UNIT_W]) begin
        acc_q <= df[UNIT_W-1:0];
        shf_q <= {shf_q[UNIT_W-2:0], 1'b1};
      end else begin
        acc_q <= rn;
        shf_q <= {shf_q[UNIT_W-2:0], 1'b0};
      end
    end
  end

  assign resp_o.done = done_q;
  assign resp_o.quo  = shf_q;
  assign resp_o.rem  = acc_q;

endmodule
`default_nettype wire

FILE: rtl/video_out_beam_position_unit.sv
// Top level of the video-out beam position unit: registers, sequencer and ports.
//
//  channel | direction | handshake                     | payload
//  in      | input     | in_valid_i / in_stall_o       | mode, now_cycle, dither/size, offset
//  out     | output    | out_valid_o / out_stall_i     | visible, beam, status, sealed fields
//  cfg     | input     | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Register and present items are answered directly, without the arithmetic unit. Read
// and align items run the shared one-bit-per-cycle multiply/divide unit, with more
// steps in vblank than in active display. Reset clears the sequencer, status, held
// values and outputs to zero and both timing registers to one, not the intermediates.
// A new item is taken only when the sequencer is idle and no item is held at out.
`default_nettype none
module video_out_beam_position_unit
  import vobp_pkg::*;
#(
  parameter int DIM_BITS   = DIM_BITS_DEF,
  parameter int CYCLE_BITS = CYCLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [2:0]            mode_i,
  input  wire logic [CYCLE_BITS-1:0] now_cycle_i,
  input  wire logic [7:0]            dither_value_i,
  input  wire logic [DIM_BITS-1:0]   width_value_i,
  input  wire logic [DIM_BITS-1:0]   height_value_i,
  input  wire logic [POS_W-1:0]      frame_offset_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 visible_dither_o,
  output logic                       scan_phase_o,
  output logic [X_W-1:0]             beam_x_o,
  output logic [Y_W-1:0]             beam_y_o,
  output logic [DIM_BITS-1:0]        visible_width_o,
  output logic [DIM_BITS-1:0]        visible_height_o,
  output logic [1:0]                 unit_status_o,
  output logic [7:0]                 sealed_dither_o,
  output logic [DIM_BITS-1:0]        sealed_width_o,
  output logic [DIM_BITS-1:0]        sealed_height_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int PROD_BITS = (POS_W + 2 * DIM_BITS > UNIT_W) ? UNIT_W : POS_W + 2 * DIM_BITS;
  localparam int LINE_BITS = POS_W + DIM_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_POS  = 4'd1;
  localparam logic [3:0] ST_WH   = 4'd2;
  localparam logic [3:0] ST_PA   = 4'd3;
  localparam logic [3:0] ST_PB   = 4'd4;
  localparam logic [3:0] ST_SH   = 4'd5;
  localparam logic [3:0] ST_LN   = 4'd6;
  localparam logic [3:0] ST_BQ   = 4'd7;
  localparam logic [3:0] ST_AW   = 4'd8;
  localparam logic [3:0] ST_T1   = 4'd9;
  localparam logic [3:0] ST_T2   = 4'd10;
  localparam logic [3:0] ST_T3   = 4'd11;
  localparam logic [3:0] ST_XY   = 4'd12;

  logic [3:0]            state_q, state_d;
  logic [POS_W-1:0]      cpf_q, vbs_q;
  logic [7:0]            live_d_q, shown_d_q, snap_d_q;
  logic [DIM_BITS-1:0]   live_w_q, live_h_q, shown_w_q, shown_h_q, snap_w_q, snap_h_q;
  logic [CYCLE_BITS-1:0] frame_start_q;
  logic                  phase_q, out_valid_q;
  logic [X_W-1:0]        beam_col_q;
  logic [Y_W-1:0]        beam_row_q;
  logic [1:0]            status_q;
  logic [POS_W-1:0]      pos_q, span_q, br_q;
  logic                  blank_q;
  logic [DIM_BITS-1:0]   bq_q;
  logic [LINE_BITS-1:0]  a_q;
  logic [UNIT_W-1:0]     t1_q;

  arith_req_t  req;
  arith_resp_t resp;

  logic                  in_acc, out_take, cfg_wr, finish, size_zero;
  logic [POS_W-1:0]      cpf, pos_new;
  logic [CYCLE_BITS-1:0] diff_in;
  logic [Y_W:0]          y_base;
  logic [UNIT_W:0]       y_sum;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign prdata     = (paddr[2] == REG_VBS) ? 32'(vbs_q) : 32'(cpf_q);

  assign cpf       = (cpf_q == '0) ? POS_W'(1) : cpf_q;
  assign size_zero = (shown_w_q == '0) || (shown_h_q == '0);
  assign pos_new   = resp.rem[POS_W-1:0];
  // An align item restarts the frame so that exactly frame_offset cycles have gone by.
  assign diff_in   = (mode_i == MODE_ALIGN) ? CYCLE_BITS'(frame_offset_i)
                                            : now_cycle_i - frame_start_q;
  assign y_base    = blank_q ? (Y_W + 1)'(shown_h_q) : '0;
  assign y_sum     = {1'b0, resp.quo} + (UNIT_W + 1)'(y_base);
  assign finish    = resp.done && (((state_q == ST_POS) && size_zero) || (state_q == ST_XY));

  vobp_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .resp_o (resp)
  );

  always_comb begin
    req     = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (mode_i == MODE_READ || mode_i == MODE_ALIGN)) begin
          req     = '{1'b1, OP_DIV, UNIT_W'(diff_in), UNIT_W'(cpf), CNT_W'(CYCLE_BITS)};
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        if (resp.done) begin
          if (size_zero) begin
            state_d = ST_IDLE;
          end else begin
            req     = '{1'b1, OP_MUL, UNIT_W'(shown_w_q), UNIT_W'(shown_h_q),
                        CNT_W'(DIM_BITS)};
            state_d = ST_WH;
          end
        end
      end
      ST_WH: begin
        if (resp.done) begin
          if (!blank_q || vbs_q == '0) begin
            req     = '{1'b1, OP_MUL, UNIT_W'(pos_q), resp.rem, CNT_W'(POS_W)};
            state_d = ST_PA;
          end else begin
            req     = '{1'b1, OP_MUL, UNIT_W'(shown_h_q), UNIT_W'(cpf - vbs_q),
                        CNT_W'(DIM_BITS)};
            state_d = ST_SH;
          end
        end
      end
      ST_PA: begin
        if (resp.done) begin
          req     = '{1'b1, OP_DIV, resp.rem, UNIT_W'(blank_q ? cpf : vbs_q),
                      CNT_W'(PROD_BITS)};
          state_d = ST_PB;
        end
      end
      ST_PB: begin
        if (resp.done) begin
          req     = '{1'b1, OP_DIV, resp.quo, UNIT_W'(shown_w_q), CNT_W'(PROD_BITS)};
          state_d = ST_XY;
        end
      end
      ST_SH: begin
        if (resp.done) begin
          req     = '{1'b1, OP_DIV, resp.rem, UNIT_W'(vbs_q), CNT_W'(LINE_BITS)};
          state_d = ST_LN;
        end
      end
      ST_LN: begin
        if (resp.done) begin
          req     = '{1'b1, OP_DIV, resp.quo, UNIT_W'(span_q), CNT_W'(LINE_BITS)};
          state_d = ST_BQ;
        end
      end
      ST_BQ: begin
        if (resp.done) begin
          req     = '{1'b1, OP_MUL, UNIT_W'(pos_q - vbs_q), UNIT_W'(shown_w_q),
                      CNT_W'(POS_W)};
          state_d = ST_AW;
        end
      end
      ST_AW: begin
        if (resp.done) begin
          req     = '{1'b1, OP_MUL, UNIT_W'(bq_q), resp.rem, CNT_W'(DIM_BITS)};
          state_d = ST_T1;
        end
      end
      ST_T1: begin
        if (resp.done) begin
          req     = '{1'b1, OP_MUL, UNIT_W'(br_q), UNIT_W'(a_q), CNT_W'(POS_W)};
          state_d = ST_T2;
        end
      end
      ST_T2: begin
        if (resp.done) begin
          req     = '{1'b1, OP_DIV, resp.rem, UNIT_W'(span_q), CNT_W'(UNIT_W)};
          state_d = ST_T3;
        end
      end
      ST_T3: begin
        if (resp.done) begin
          req     = '{1'b1, OP_DIV, t1_q + resp.quo, UNIT_W'(shown_w_q), CNT_W'(UNIT_W)};
          state_d = ST_XY;
        end
      end
      ST_XY: begin
        if (resp.done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Intermediate values of the beam computation.
  always_ff @(posedge clk_i) begin
    if (resp.done) begin
      case (state_q)
        ST_POS: begin
          pos_q   <= pos_new;
          blank_q <= (vbs_q == '0) || (pos_new >= vbs_q);
          span_q  <= cpf - vbs_q;
        end
        ST_BQ: begin
          bq_q <= resp.quo[DIM_BITS-1:0];
          br_q <= resp.rem[POS_W-1:0];
        end
        ST_AW:   a_q  <= resp.rem[LINE_BITS-1:0];
        ST_T1:   t1_q <= resp.rem;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cpf_q         <= POS_W'(1);
      vbs_q         <= POS_W'(1);
      live_d_q      <= '0;
      live_w_q      <= '0;
      live_h_q      <= '0;
      shown_d_q     <= '0;
      shown_w_q     <= '0;
      shown_h_q     <= '0;
      snap_d_q      <= '0;
      snap_w_q      <= '0;
      snap_h_q      <= '0;
      frame_start_q <= '0;
      phase_q       <= 1'b0;
      beam_col_q    <= '0;
      beam_row_q    <= '0;
      status_q      <= STAT_IDLE;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (paddr[2] == REG_VBS) begin
          vbs_q <= pwdata[POS_W-1:0];
        end else begin
          cpf_q <= pwdata[POS_W-1:0];
        end
      end
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        case (mode_i)
          MODE_DITHER: begin
            live_d_q    <= dither_value_i;
            status_q    <= STAT_LATCHED;
            out_valid_q <= 1'b1;
          end
          MODE_SIZE: begin
            live_w_q    <= width_value_i;
            live_h_q    <= height_value_i;
            status_q    <= STAT_LATCHED;
            out_valid_q <= 1'b1;
          end
          MODE_SEAL: begin
            snap_d_q    <= live_d_q;
            snap_w_q    <= live_w_q;
            snap_h_q    <= live_h_q;
            status_q    <= STAT_SEALED;
            out_valid_q <= 1'b1;
          end
          MODE_PRES_LV: begin
            shown_d_q   <= live_d_q;
            shown_w_q   <= live_w_q;
            shown_h_q   <= live_h_q;
            status_q    <= STAT_SHOWN;
            out_valid_q <= 1'b1;
          end
          MODE_PRES_FR: begin
            shown_d_q   <= dither_value_i;
            shown_w_q   <= width_value_i;
            shown_h_q   <= height_value_i;
            status_q    <= STAT_SHOWN;
            out_valid_q <= 1'b1;
          end
          MODE_ALIGN: begin
            frame_start_q <= now_cycle_i - CYCLE_BITS'(frame_offset_i);
          end
          MODE_REINIT: begin
            live_d_q      <= dither_value_i;
            shown_d_q     <= dither_value_i;
            snap_d_q      <= dither_value_i;
            live_w_q      <= width_value_i;
            shown_w_q     <= width_value_i;
            snap_w_q      <= width_value_i;
            live_h_q      <= height_value_i;
            shown_h_q     <= height_value_i;
            snap_h_q      <= height_value_i;
            frame_start_q <= '0;
            cpf_q         <= POS_W'(1);
            vbs_q         <= POS_W'(1);
            phase_q       <= 1'b0;
            beam_col_q    <= '0;
            beam_row_q    <= '0;
            status_q      <= STAT_IDLE;
            out_valid_q   <= 1'b1;
          end
          default: ;
        endcase
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        if (state_q == ST_POS) begin
          phase_q    <= (vbs_q == '0) || (pos_new >= vbs_q);
          beam_col_q <= '0;
          beam_row_q <= '0;
        end else begin
          phase_q    <= blank_q;
          beam_col_q <= (resp.rem > UNIT_W'(X_MAX)) ? X_MAX : resp.rem[X_W-1:0];
          beam_row_q <= (y_sum > (UNIT_W + 1)'(Y_MAX)) ? Y_MAX : y_sum[Y_W-1:0];
        end
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign visible_dither_o = shown_d_q;
  assign scan_phase_o     = phase_q;
  assign beam_x_o         = beam_col_q;
  assign beam_y_o         = beam_row_q;
  assign visible_width_o  = shown_w_q;
  assign visible_height_o = shown_h_q;
  assign unit_status_o    = status_q;
  assign sealed_dither_o  = snap_d_q;
  assign sealed_width_o   = snap_w_q;
  assign sealed_height_o  = snap_h_q;

  // The shared unit only reports while the sequencer waits on it.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp.done |-> state_q != ST_IDLE)
    else $error("arith unit finished with sequencer idle");

  // No result may be pending while a beam computation is running.
  a_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !out_valid_q)
    else $error("result pending during computation");

  // The frame position must come out below the frame length.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POS && resp.done) |-> resp.rem < UNIT_W'(cpf))
    else $error("frame position not below frame length");

endmodule
`default_nettype wire

FILE: tb/vobp_checker.sv
// Checker for the video-out beam position unit: predicts every result and compares it.
`timescale 1ns / 100ps
module vobp_checker
  import vobp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [2:0]  mode_i,
  input  wire logic [47:0] now_cycle_i,
  input  wire logic [7:0]  dither_value_i,
  input  wire logic [12:0] width_value_i,
  input  wire logic [12:0] height_value_i,
  input  wire logic [23:0] frame_offset_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [7:0]  visible_dither_i,
  input  wire logic        scan_phase_i,
  input  wire logic [11:0] beam_x_i,
  input  wire logic [13:0] beam_y_i,
  input  wire logic [12:0] visible_width_i,
  input  wire logic [12:0] visible_height_i,
  input  wire logic [1:0]  unit_status_i,
  input  wire logic [7:0]  sealed_dither_i,
  input  wire logic [12:0] sealed_width_i,
  input  wire logic [12:0] sealed_height_i,
  // Register writes as the top performs them.
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [31:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               result_count_o
);

  typedef struct packed {
    logic [7:0]  vis_dither;
    logic        phase;
    logic [11:0] bx;
    logic [13:0] by;
    logic [12:0] vis_w;
    logic [12:0] vis_h;
    logic [1:0]  status;
    logic [7:0]  snp_dither;
    logic [12:0] snp_w;
    logic [12:0] snp_h;
  } view_t;

  view_t       expected_views[$];
  logic [23:0] frame_len, blank_at;
  logic [7:0]  lv_d, sh_d, sn_d;
  logic [12:0] lv_w, lv_h, sh_w, sh_h, sn_w, sn_h;
  logic [47:0] start_cycle;
  logic        phase;
  logic [11:0] col;
  logic [13:0] row;
  logic [1:0]  status;

  assign pending_o = expected_views.size();

  task automatic place_beam(input logic [63:0] pixel, input logic [63:0] w,
                            input logic [63:0] base);
    logic [63:0] x, y;
    x = pixel % w;
    y = base + pixel / w;
    col = (x > 64'd4095) ? 12'hFFF : x[11:0];
    row = (y > 64'd16383) ? 14'h3FFF : y[13:0];
  endtask

  task automatic update_beam(input logic [47:0] now);
    logic [63:0] cpf, vs, pos, w, h, span, lines, a, bq, br;
    logic        blank;
    cpf = (frame_len == 0) ? 64'd1 : {40'd0, frame_len};
    vs = {40'd0, blank_at};
    pos = {16'd0, now - start_cycle} % cpf;
    blank = (vs == 0) || (pos >= vs);
    w = {51'd0, sh_w};
    h = {51'd0, sh_h};
    phase = blank;
    if (w == 0 || h == 0) begin
      col = '0;
      row = '0;
    end else if (!blank) begin
      place_beam(pos * (w * h) / vs, w, 0);
    end else if (vs == 0) begin
      place_beam(pos * (w * h) / cpf, w, h);
    end else begin
      span = cpf - vs;
      lines = span * h / vs;
      a = (pos - vs) * w;
      bq = lines / span;
      br = lines % span;
      place_beam(a * bq + (a * br) / span, w, h);
    end
  endtask

  task automatic load_all(input logic [7:0] d, input logic [12:0] w, input logic [12:0] h);
    lv_d = d; sh_d = d; sn_d = d;
    lv_w = w; sh_w = w; sn_w = w;
    lv_h = h; sh_h = h; sn_h = h;
    phase = 0; col = 0; row = 0; start_cycle = 0;
    frame_len = 1; blank_at = 1; status = STAT_IDLE;
  endtask

  task automatic predict_item();
    view_t v;
    case (mode_i)
      MODE_READ: update_beam(now_cycle_i);
      MODE_DITHER: begin
        lv_d = dither_value_i;
        status = STAT_LATCHED;
      end
      MODE_SIZE: begin
        lv_w = width_value_i;
        lv_h = height_value_i;
        status = STAT_LATCHED;
      end
      MODE_SEAL: begin
        sn_d = lv_d; sn_w = lv_w; sn_h = lv_h;
        status = STAT_SEALED;
      end
      MODE_PRES_LV: begin
        sh_d = lv_d; sh_w = lv_w; sh_h = lv_h;
        status = STAT_SHOWN;
      end
      MODE_PRES_FR: begin
        sh_d = dither_value_i; sh_w = width_value_i; sh_h = height_value_i;
        status = STAT_SHOWN;
      end
      MODE_ALIGN: begin
        start_cycle = now_cycle_i - {24'd0, frame_offset_i};
        update_beam(now_cycle_i);
      end
      default: load_all(dither_value_i, width_value_i, height_value_i);
    endcase
    v = '{sh_d, phase, col, row, sh_w, sh_h, status, sn_d, sn_w, sn_h};
    expected_views.push_back(v);
  endtask

  task automatic compare_view();
    view_t e;
    if (expected_views.size() == 0) begin
      $error("result without a pending item");
      fail_count_o++;
      return;
    end
    e = expected_views.pop_front();
    if (visible_dither_i !== e.vis_dither) begin
      $error("visible_dither exp %0d got %0d", e.vis_dither, visible_dither_i);
      fail_count_o++;
    end
    if (scan_phase_i !== e.phase) begin
      $error("scan_phase exp %0d got %0d", e.phase, scan_phase_i);
      fail_count_o++;
    end
    if (beam_x_i !== e.bx) begin
      $error("beam_x exp %0d got %0d", e.bx, beam_x_i);
      fail_count_o++;
    end
    if (beam_y_i !== e.by) begin
      $error("beam_y exp %0d got %0d", e.by, beam_y_i);
      fail_count_o++;
    end
    if (visible_width_i !== e.vis_w) begin
      $error("visible_width exp %0d got %0d", e.vis_w, visible_width_i);
      fail_count_o++;
    end
    if (visible_height_i !== e.vis_h) begin
      $error("visible_height exp %0d got %0d", e.vis_h, visible_height_i);
      fail_count_o++;
    end
    if (unit_status_i !== e.status) begin
      $error("unit_status exp %0d got %0d", e.status, unit_status_i);
      fail_count_o++;
    end
    if (sealed_dither_i !== e.snp_dither) begin
      $error("sealed_dither exp %0d got %0d", e.snp_dither, sealed_dither_i);
      fail_count_o++;
    end
    if (sealed_width_i !== e.snp_w) begin
      $error("sealed_width exp %0d got %0d", e.snp_w, sealed_width_i);
      fail_count_o++;
    end
    if (sealed_height_i !== e.snp_h) begin
      $error("sealed_height exp %0d got %0d", e.snp_h, sealed_height_i);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    result_count_o = 0;
    load_all(0, 0, 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_addr_i == 3'd0) frame_len = cfg_data_i[23:0];
        else if (cfg_addr_i == 3'd4) blank_at = cfg_data_i[23:0];
      end
      if (in_valid_i && !in_stall_i) predict_item();
      if (out_valid_i && !out_stall_i) begin
        compare_view();
        result_count_o++;
      end
    end
  end

endmodule

FILE: tb/tb_video_out_beam_position_unit.sv
// Testbench top for the video-out beam position unit: stimulus, register writes and verdict.
`timescale 1ns / 100ps
module tb_video_out_beam_position_unit;
  import vobp_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  mode = MODE_READ;
  logic [47:0] now_cycle = '0;
  logic [7:0]  dither_value = '0;
  logic [12:0] width_value = '0;
  logic [12:0] height_value = '0;
  logic [23:0] frame_offset = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  visible_dither, sealed_dither;
  logic        scan_phase;
  logic [11:0] beam_x;
  logic [13:0] beam_y;
  logic [12:0] visible_width, visible_height, sealed_width, sealed_height;
  logic [1:0]  unit_status;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, result_count;
  int          items_sent = 0;
  bit          hold_off = 0;
  bit          stim_done = 0;

  always #6 clk_i = ~clk_i;

  video_out_beam_position_unit i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .now_cycle_i(now_cycle), .dither_value_i(dither_value),
    .width_value_i(width_value), .height_value_i(height_value),
    .frame_offset_i(frame_offset),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .visible_dither_o(visible_dither), .scan_phase_o(scan_phase),
    .beam_x_o(beam_x), .beam_y_o(beam_y),
    .visible_width_o(visible_width), .visible_height_o(visible_height),
    .unit_status_o(unit_status), .sealed_dither_o(sealed_dither),
    .sealed_width_o(sealed_width), .sealed_height_o(sealed_height),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  vobp_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .mode_i(mode), .now_cycle_i(now_cycle), .dither_value_i(dither_value),
    .width_value_i(width_value), .height_value_i(height_value),
    .frame_offset_i(frame_offset),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .visible_dither_i(visible_dither), .scan_phase_i(scan_phase),
    .beam_x_i(beam_x), .beam_y_i(beam_y),
    .visible_width_i(visible_width), .visible_height_i(visible_height),
    .unit_status_i(unit_status), .sealed_dither_i(sealed_dither),
    .sealed_width_i(sealed_width), .sealed_height_i(sealed_height),
    .cfg_we_i(psel && penable && pwrite && pready), .cfg_addr_i(paddr),
    .cfg_data_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // The receiver stalls in runs, and during a hold-off stalls without a break.
  always @(posedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_stall <= 1'($urandom_range(0, 1));
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (450) @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [23:0] cpf, input logic [23:0] vbs);
    drain();
    write_reg(3'd0, {8'd0, cpf});
    write_reg(3'd4, {8'd0, vbs});
  endtask

  task automatic send(input logic [2:0] m, input logic [47:0] now, input logic [7:0] d,
                      input logic [12:0] w, input logic [12:0] h, input logic [23:0] off);
    in_valid <= 1;
    mode <= m; now_cycle <= now; dither_value <= d;
    width_value <= w; height_value <= h; frame_offset <= off;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0;
    if (n != 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [12:0] rand_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 13'd0;
    if (r == 1) return 13'd4096;
    if (r < 5) return 13'($urandom_range(1, 16));
    if (r == 5) return 13'($urandom_range(0, 8191));
    return 13'($urandom_range(1, 4096));
  endfunction

  // A random mix: mostly reads and register or present items, some aligns, rarely a reinit.
  task automatic random_item();
    logic [2:0]  m;
    logic [47:0] now;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 40) m = MODE_READ;
    else if (r < 50) m = MODE_ALIGN;
    else if (r < 98) m = 3'($urandom_range(1, 5));
    else m = MODE_REINIT;
    now = 48'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) now = 48'($urandom_range(0, 5000));
    send(m, now, 8'($urandom), rand_dim(), rand_dim(), 24'($urandom));
    idle_gap();
  endtask

  task automatic random_phase(input int count);
    repeat (count) random_item();
    in_valid <= 0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: register ops, presents, zero size, reinit, every mode.
    send(MODE_READ, 48'd0, 8'd0, 13'd0, 13'd0, 24'd0);
    send(MODE_DITHER, 48'd0, 8'hFF, 13'd0, 13'd0, 24'd0);
    send(MODE_SIZE, 48'd0, 8'd0, 13'd4096, 13'd4096, 24'd0);
    send(MODE_SEAL, 48'd0, 8'd0, 13'd0, 13'd0, 24'd0);
    send(MODE_PRES_LV, 48'd0, 8'd0, 13'd0, 13'd0, 24'd0);
    send(MODE_READ, 48'hFFFF_FFFF_FFFF, 8'd0, 13'd0, 13'd0, 24'd0);
    send(MODE_PRES_FR, 48'd0, 8'h5A, 13'h1FFF, 13'd1, 24'd0);
    send(MODE_READ, 48'd7, 8'd0, 13'd0, 13'd0, 24'd0);
    send(MODE_REINIT, 48'd0, 8'hA5, 13'd640, 13'd480, 24'd0);
    send(MODE_READ, 48'd3, 8'd0, 13'd0, 13'd0, 24'd0);
    in_valid <= 0;

    set_timing(24'd1000, 24'd800);
    send(MODE_ALIGN, 48'd100, 8'd0, 13'd0, 13'd0, 24'hFFFFFF);
    send(MODE_READ, 48'd500, 8'd0, 13'd0, 13'd0, 24'd0);
    send(MODE_READ, 48'd900, 8'd0, 13'd0, 13'd0, 24'd0);
    send(MODE_READ, 48'd0, 8'd0, 13'd0, 13'd0, 24'd0);
    send(MODE_PRES_FR, 48'd0, 8'd1, 13'd0, 13'd10, 24'd0);
    send(MODE_READ, 48'd850, 8'd0, 13'd0, 13'd0, 24'd0);
    send(MODE_PRES_FR, 48'd0, 8'd2, 13'd4096, 13'd4096, 24'd0);
    send(MODE_READ, 48'd999, 8'd0, 13'd0, 13'd0, 24'd0);
    in_valid <= 0;

    set_timing(24'd0, 24'd0);
    send(MODE_READ, 48'd12345, 8'd0, 13'd0, 13'd0, 24'd0);
    in_valid <= 0;
    set_timing(24'hFFFFFF, 24'hFFFFFF);
    send(MODE_READ, 48'hABCDEF012345, 8'd0, 13'd0, 13'd0, 24'd0);
    in_valid <= 0;
    set_timing(24'd100, 24'd200);
    send(MODE_READ, 48'd150, 8'd0, 13'd0, 13'd0, 24'd0);
    in_valid <= 0;

    set_timing(24'($urandom_range(1, 5000)), 24'($urandom_range(0, 5000)));
    random_phase(400);
    // Long receiver hold-off while the sender keeps offering items.
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      random_phase(30);
    join
    // Sender pauses until the block has delivered everything.
    while (pending != 0) @(posedge clk_i);
    random_phase(300);
    set_timing(24'hFFFFFF, 24'($urandom_range(0, 24'hFFFFFF)));
    random_phase(400);
    set_timing(24'($urandom_range(1, 64)), 24'($urandom_range(0, 64)));
    random_phase(400);
    set_timing(24'($urandom), 24'd0);
    random_phase(350);
    drain();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    $display("Covered %0d items and %0d results over eight timing settings.",
             items_sent, result_count);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
